### src/easing_curve_evaluator_top_defines.svh
// Assertion shorthands for the easing curve evaluator.
`ifndef EASING_CURVE_EVALUATOR_TOP_DEFINES_SVH
`define EASING_CURVE_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ECE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ECE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ece_pkg.sv
package ece_pkg;

  // Number formats
  localparam int FRAC_BITS = 16;
  localparam int IW        = 30;              // internal fraction bits
  localparam int SH        = IW - FRAC_BITS;  // internal to external shift
  localparam int XW        = FRAC_BITS + 1;   // clamped progress, 0..1.0
  localparam int ONE_INT   = 1 << FRAC_BITS;

  typedef logic [3:0]         func_t;
  typedef logic signed [17:0] prog_t;
  typedef logic signed [17:0] eased_t;
  typedef logic [XW-1:0]      xval_t;

  localparam xval_t  ONE_X      = xval_t'(ONE_INT);
  localparam xval_t  HALF_X     = xval_t'(ONE_INT / 2);
  localparam eased_t EASED_MAX  = {1'b0, {17{1'b1}}};
  localparam eased_t EASED_MIN  = {1'b1, {17{1'b0}}};

  // Curve selector codes
  localparam func_t FN_LIN      = 4'd0;
  localparam func_t FN_IN       = 4'd1;
  localparam func_t FN_OUT      = 4'd2;
  localparam func_t FN_INOUT    = 4'd3;
  localparam func_t FN_IN_EL    = 4'd4;
  localparam func_t FN_OUT_EL   = 4'd5;
  localparam func_t FN_INOUT_EL = 4'd6;
  localparam func_t FN_STEP     = 4'd7;
  localparam func_t FN_INST     = 4'd8;

  // Q30 constants
  localparam logic [30:0] Q1         = 31'(64'd1 << IW);
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  // Elastic phase numerators (in units of one progress LSB) and rounded-up reciprocals
  localparam logic [21:0] PH_OFS_IN  = 22'(12 * ONE_INT - 43 * ONE_INT / 4);
  localparam logic [21:0] PH_OFS_OUT = 22'(3 * ONE_INT - 3 * ONE_INT / 4);
  localparam logic [21:0] PH_OFS_IO  = 22'(27 * ONE_INT - 89 * ONE_INT / 4);
  localparam int          PH_RSH     = 28;
  localparam logic [26:0] PH_M3      = 27'(((64'd1 << PH_RSH) + 64'd2) / 64'd3);
  localparam logic [26:0] PH_M9      = 27'(((64'd1 << PH_RSH) + 64'd8) / 64'd9);

  // Pipeline layout
  localparam int SLOT_BASE = 6;                         // first series stage
  localparam int EXP_SLOTS = 11;                        // exp2 terms k = 2..12
  localparam int SIN_SLOTS = 7;                         // sin terms k = 1..7
  localparam int STG_E     = SLOT_BASE + 3 * EXP_SLOTS; // exp finish and product
  localparam int STG_OUT   = STG_E + 1;                 // curve select and rounding
  localparam int NST       = STG_OUT + 1;

  // Fraction part of remainder * 2^SH / d for the phase divide (d = 3 or 9)
  function automatic logic [SH-1:0] ph_frac(input logic [3:0] rem, input logic d9);
    logic [SH-1:0] f;
    case ({d9, rem})
      5'b0_0001: f = 14'd5461;
      5'b0_0010: f = 14'd10922;
      5'b1_0001: f = 14'd1820;
      5'b1_0010: f = 14'd3640;
      5'b1_0011: f = 14'd5461;
      5'b1_0100: f = 14'd7281;
      5'b1_0101: f = 14'd9102;
      5'b1_0110: f = 14'd10922;
      5'b1_0111: f = 14'd12743;
      5'b1_1000: f = 14'd14563;
      default:   f = '0;
    endcase
    return f;
  endfunction

endpackage

### src/ece_if.sv
// Request channel: curve selector and progress
interface ece_in_if import ece_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  prog_t progress;

  modport source (output valid, func, progress, input ready);
  modport sink   (input valid, func, progress, output ready);
endinterface

// Result channel: eased value
interface ece_out_if import ece_pkg::*; ();
  logic   valid;
  logic   ready;
  eased_t eased;

  modport source (output valid, eased, input ready);
  modport sink   (input valid, eased, output ready);
endinterface

### src/easing_curve_evaluator_top.sv
// Easing curve evaluator. Each request carries a curve selector and a signed progress value
// with 16 fraction bits; progress is clamped to 0..1.0 and the eased value is returned in the
// same format. One request is taken every clock cycle while the pipeline is not stalled, and its
// result leaves through the output register. The pipeline depth is set by the exp2 series: eleven
// multiply, reciprocal and correct steps of three stages each, with the sine series and the
// cubic curves running alongside. A two-entry output buffer keeps the input open while a
// result waits to be taken; the pipeline only stalls once both entries are full.
`include "easing_curve_evaluator_top_defines.svh"

module easing_curve_evaluator_top import ece_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ece_in_if.sink    in_chan,
  ece_out_if.source out_chan
);

  typedef struct packed {
    func_t              fn;
    xval_t              x;
    xval_t              w;      // cube base
    logic [2*XW-1:0]    ww;
    logic [30:0]        c;      // cube, Q30
    logic [21:0]        ph_n;   // phase numerator
    logic [48:0]        ph_q;
    logic               ph_d9;
    logic [29:0]        p;      // phase in turns, Q30
    logic [1:0]         quad;
    logic [61:0]        rp;
    logic [30:0]        a;      // angle, Q30
    logic [61:0]        aa;
    logic [31:0]        a2;
    logic [3:0]         ip;     // exp2 integer part
    logic               frz;    // exp2 fraction is zero
    logic [29:0]        u;
    logic [30:0]        te;     // exp2 term
    logic [31:0]        se;     // exp2 sum
    logic [60:0]        pe;
    logic [31:0]        ne;
    logic [63:0]        qe;
    logic [30:0]        ts;     // sin term
    logic signed [32:0] ss;     // sin sum
    logic [62:0]        ps;
    logic [31:0]        ns;
    logic [63:0]        qs;
    logic [62:0]        prod;
    eased_t             eased;
  } pipe_t;

  pipe_t          pipe_r [NST];
  logic [NST-1:0] vld_r;
  logic           pipe_en;
  logic           in_acc;
  logic           out_take;
  logic           out_valid_r;
  eased_t         eased_r;
  logic           sk_vld_r;
  eased_t         sk_eased_r;
  pipe_t          stg0_nxt;

  assign pipe_en        = !sk_vld_r;
  assign in_chan.ready  = pipe_en;
  assign in_acc         = in_chan.valid && pipe_en;
  assign out_take       = out_valid_r && out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.eased = eased_r;

  // Valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NST-2:0], in_acc};
    end
  end

  // Stage 0: register the request, clamp progress
  always_comb begin
    stg0_nxt    = '0;
    stg0_nxt.fn = in_chan.func;
    if (in_chan.progress < 0) begin
      stg0_nxt.x = '0;
    end else if (in_chan.progress > $signed(18'(ONE_X))) begin
      stg0_nxt.x = ONE_X;
    end else begin
      stg0_nxt.x = in_chan.progress[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pipe_r[0] <= stg0_nxt;
    end
  end

  genvar gi;
  for (gi = 1; gi < NST; gi++) begin : g_stage
    pipe_t stg_nxt;

    if (gi == 1) begin : g_s1
      // Cube base, exp2 argument split, phase numerator times reciprocal
      logic        lower;
      logic [19:0] arg;
      logic [16:0] fpart;
      logic [46:0] lp;
      logic [21:0] n_ph;
      always_comb begin
        stg_nxt = pipe_r[gi-1];
        lower   = pipe_r[gi-1].x < HALF_X;
        case (pipe_r[gi-1].fn)
          FN_OUT:   stg_nxt.w = ONE_X - pipe_r[gi-1].x;
          FN_INOUT: stg_nxt.w = lower ? pipe_r[gi-1].x : xval_t'((ONE_X - pipe_r[gi-1].x) << 1);
          default:  stg_nxt.w = pipe_r[gi-1].x;
        endcase
        stg_nxt.ww = stg_nxt.w * stg_nxt.w;
        case (pipe_r[gi-1].fn)
          FN_IN_EL:    arg = 20'd10 * (20'(ONE_X) - 20'(pipe_r[gi-1].x));
          FN_INOUT_EL: arg = lower ? 20'd10 * 20'(ONE_X) - 20'd20 * 20'(pipe_r[gi-1].x)
                                   : 20'd20 * 20'(pipe_r[gi-1].x) - 20'd10 * 20'(ONE_X);
          default:     arg = 20'd10 * 20'(pipe_r[gi-1].x);
        endcase
        stg_nxt.ip  = arg[19:16];
        stg_nxt.frz = (arg[15:0] == '0);
        fpart       = 17'(ONE_X) - {1'b0, arg[15:0]};
        lp          = fpart * LN2_Q30;
        stg_nxt.u   = lp[45:16];
        case (pipe_r[gi-1].fn)
          FN_IN_EL: begin
            n_ph          = 22'd10 * 22'(pipe_r[gi-1].x) + PH_OFS_IN;
            stg_nxt.ph_d9 = 1'b0;
          end
          FN_INOUT_EL: begin
            n_ph          = 22'd40 * 22'(pipe_r[gi-1].x) + PH_OFS_IO;
            stg_nxt.ph_d9 = 1'b1;
          end
          default: begin
            n_ph          = 22'd10 * 22'(pipe_r[gi-1].x) + PH_OFS_OUT;
            stg_nxt.ph_d9 = 1'b0;
          end
        endcase
        stg_nxt.ph_n = n_ph;
        stg_nxt.ph_q = n_ph * (stg_nxt.ph_d9 ? PH_M9 : PH_M3);
      end

    end else if (gi == 2) begin : g_s2
      // Finish cube, finish phase divide, seed exp2 series
      logic [48:0] cp;
      logic [20:0] q1;
      logic [21:0] rem;
      always_comb begin
        stg_nxt    = pipe_r[gi-1];
        cp         = 49'(pipe_r[gi-1].ww[2*XW-1:2]) * 49'(pipe_r[gi-1].w);
        stg_nxt.c  = cp[46:16];
        q1         = pipe_r[gi-1].ph_q[48:PH_RSH];
        rem        = pipe_r[gi-1].ph_n - 22'(q1) * (pipe_r[gi-1].ph_d9 ? 22'd9 : 22'd3);
        stg_nxt.p  = {q1[15:0], ph_frac(rem[3:0], pipe_r[gi-1].ph_d9)};
        stg_nxt.te = {1'b0, pipe_r[gi-1].u};
        stg_nxt.se = 32'(Q1) + 32'(pipe_r[gi-1].u);
      end

    end else if (gi == 3) begin : g_s3
      // Quarter-turn reduction, angle product
      logic [28:0] r29;
      always_comb begin
        stg_nxt      = pipe_r[gi-1];
        stg_nxt.quad = pipe_r[gi-1].p[29:28];
        r29          = stg_nxt.quad[0] ? (29'd1 << 28) - 29'(pipe_r[gi-1].p[27:0])
                                       : 29'(pipe_r[gi-1].p[27:0]);
        stg_nxt.rp   = r29 * TWO_PI_Q30;
      end

    end else if (gi == 4) begin : g_s4
      always_comb begin
        stg_nxt    = pipe_r[gi-1];
        stg_nxt.a  = pipe_r[gi-1].rp[60:30];
        stg_nxt.aa = stg_nxt.a * stg_nxt.a;
      end

    end else if (gi == 5) begin : g_s5
      // Seed sin series
      always_comb begin
        stg_nxt    = pipe_r[gi-1];
        stg_nxt.a2 = pipe_r[gi-1].aa[61:30];
        stg_nxt.ts = pipe_r[gi-1].a;
        stg_nxt.ss = $signed(33'(pipe_r[gi-1].a));
      end

    end else if (gi < STG_E) begin : g_slot
      // One series term per three stages: multiply, reciprocal multiply, correct
      localparam int          SLOT    = (gi - SLOT_BASE) / 3;
      localparam int          PH      = (gi - SLOT_BASE) % 3;
      localparam int          KE      = SLOT + 2;
      localparam int          KS      = (2 * SLOT + 2) * (2 * SLOT + 3);
      localparam logic [31:0] ME      = 32'((64'd1 << 32) / KE);
      localparam logic [31:0] MS      = 32'((64'd1 << 32) / KS);
      localparam bit          SIN_ON  = SLOT < SIN_SLOTS;
      localparam bit          SIN_SUB = (SLOT % 2) == 0;
      logic [31:0] q0e, re, qfe;
      logic [31:0] q0s, rs, qfs;
      always_comb begin
        stg_nxt = pipe_r[gi-1];
        q0e     = pipe_r[gi-1].qe[63:32];
        re      = pipe_r[gi-1].ne - q0e * 32'(KE);
        qfe     = (re >= 32'(KE)) ? q0e + 32'd1 : q0e;
        q0s     = pipe_r[gi-1].qs[63:32];
        rs      = pipe_r[gi-1].ns - q0s * 32'(KS);
        qfs     = (rs >= 32'(KS)) ? q0s + 32'd1 : q0s;
        if (PH == 0) begin
          stg_nxt.pe = pipe_r[gi-1].te * pipe_r[gi-1].u;
          if (SIN_ON) begin
            stg_nxt.ps = pipe_r[gi-1].ts * pipe_r[gi-1].a2;
          end
        end else if (PH == 1) begin
          stg_nxt.ne = {1'b0, pipe_r[gi-1].pe[60:30]};
          stg_nxt.qe = stg_nxt.ne * ME;
          if (SIN_ON) begin
            stg_nxt.ns = pipe_r[gi-1].ps[61:30];
            stg_nxt.qs = stg_nxt.ns * MS;
          end
        end else begin
          stg_nxt.te = qfe[30:0];
          stg_nxt.se = pipe_r[gi-1].se + qfe;
          if (SIN_ON) begin
            stg_nxt.ts = qfs[30:0];
            if (SIN_SUB) begin
              stg_nxt.ss = pipe_r[gi-1].ss - $signed(33'(qfs));
            end else begin
              stg_nxt.ss = pipe_r[gi-1].ss + $signed(33'(qfs));
            end
          end
        end
      end

    end else if (gi == STG_E) begin : g_se
      // Scale exp2 by its integer part, multiply by |sin|
      logic [31:0] ev;
      always_comb begin
        stg_nxt = pipe_r[gi-1];
        if (pipe_r[gi-1].frz) begin
          ev = 32'(Q1) >> pipe_r[gi-1].ip;
        end else begin
          ev = pipe_r[gi-1].se >> (5'(pipe_r[gi-1].ip) + 5'd1);
        end
        stg_nxt.prod = ev[30:0] * pipe_r[gi-1].ss[31:0];
      end

    end else begin : g_sout
      // Curve select, round to output format, saturate
      localparam logic signed [34:0] Q1S = $signed(35'(Q1));
      logic                neg;
      logic                lower;
      logic                at_end;
      logic signed [34:0]  xs, cs, ch, ms, mh, v, vs;
      always_comb begin
        stg_nxt = pipe_r[gi-1];
        neg     = pipe_r[gi-1].quad[1];
        lower   = pipe_r[gi-1].x < HALF_X;
        at_end  = (pipe_r[gi-1].x == '0) || (pipe_r[gi-1].x == ONE_X);
        xs      = $signed(35'(pipe_r[gi-1].x) << SH);
        cs      = $signed(35'(pipe_r[gi-1].c));
        ch      = $signed(35'(pipe_r[gi-1].c >> 1));
        ms      = $signed(35'(pipe_r[gi-1].prod[62:30]));
        mh      = $signed(35'(pipe_r[gi-1].prod[62:31]));
        case (pipe_r[gi-1].fn)
          FN_LIN:      v = xs;
          FN_IN:       v = cs;
          FN_OUT:      v = Q1S - cs;
          FN_INOUT:    v = lower ? cs <<< 2 : Q1S - ch;
          FN_IN_EL:    v = at_end ? xs : (neg ? ms : -ms);
          FN_OUT_EL:   v = at_end ? xs : (neg ? -ms : ms) + Q1S;
          FN_INOUT_EL: v = at_end ? xs : (lower ? (neg ? mh : -mh) : (neg ? -mh : mh) + Q1S);
          FN_STEP:     v = lower ? '0 : Q1S;
          FN_INST:     v = Q1S;
          default:     v = -Q1S;
        endcase
        vs = (v + $signed(35'(1) << (SH - 1))) >>> SH;
        if (vs > 35'(EASED_MAX)) begin
          stg_nxt.eased = EASED_MAX;
        end else if (vs < 35'(EASED_MIN)) begin
          stg_nxt.eased = EASED_MIN;
        end else begin
          stg_nxt.eased = vs[17:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        pipe_r[gi] <= stg_nxt;
      end
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_vld_r    <= 1'b0;
    end else if (sk_vld_r) begin
      if (out_take) begin
        eased_r  <= sk_eased_r;
        sk_vld_r <= 1'b0;
      end
    end else if (vld_r[NST-1]) begin
      if (!out_valid_r || out_take) begin
        eased_r     <= pipe_r[NST-1].eased;
        out_valid_r <= 1'b1;
      end else begin
        sk_eased_r <= pipe_r[NST-1].eased;
        sk_vld_r   <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Checks
  `ECE_ASSERT_IMP(a_skid_behind_out, sk_vld_r, out_valid_r, "skid entry held with empty output")
  `ECE_ASSERT_NXT(a_accept_enters, in_acc, vld_r[0], "accepted request missing from stage 0")
  `ECE_ASSERT_NXT(a_stall_holds, (!pipe_en && vld_r[NST-1]), (vld_r[NST-1] && $stable(pipe_r[NST-1].eased)), "last stage changed while stalled")

endmodule

### test/tb.sv
`default_nettype none

module tb;
  import ece_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned QTR30 = 64'd1 << 28;
  localparam longint unsigned LN2_C = 64'd744261118;
  localparam longint unsigned TWOPI_C = 64'd6746518852;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ece_in_if  in_chan ();
  ece_out_if out_chan ();

  easing_curve_evaluator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  eased_t eased_q[$];
  int     mismatch_cnt = 0;
  int     result_cnt = 0;
  int     req_cnt = 0;
  int     quiet_cycles = 0;
  bit     no_idle = 1'b0;
  int     per_func[16];

  // 2^(-a), Q30 in and out
  function automatic longint unsigned pow2_neg(input longint unsigned a);
    longint unsigned ip, fr, f, u, acc, t, sh;
    ip = a >> 30;
    fr = a & (ONE30 - 1);
    if (fr == 0) return (ip >= 62) ? 64'd0 : (ONE30 >> ip);
    f = ONE30 - fr;
    u = (f * LN2_C) >> 30;
    acc = ONE30;
    t = ONE30;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * u) >> 30) / k;
      acc += t;
    end
    sh = ip + 1;
    return (sh >= 62) ? 64'd0 : (acc >> sh);
  endfunction

  // sin of a phase given in turns (Q30, modulo one turn)
  function automatic longint sine_turns(input longint unsigned p);
    longint unsigned q, r, a, a2, t;
    longint acc;
    p &= ONE30 - 1;
    q = p >> 28;
    r = p & (QTR30 - 1);
    if (q[0]) r = QTR30 - r;
    a = (r * TWOPI_C) >> 30;
    a2 = (a * a) >> 30;
    t = a;
    acc = longint'(a);
    for (int k = 1; k <= 7; k++) begin
      t = ((t * a2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    return q[1] ? -acc : acc;
  endfunction

  function automatic longint scale_signed(input longint unsigned e, input longint s);
    longint unsigned m;
    longint mag;
    m = (s < 0) ? longint'(-s) : s;
    mag = longint'((e * m) >> 30);
    return (s < 0) ? -mag : mag;
  endfunction

  function automatic longint cubed(input longint unsigned v);
    return longint'((((v * v) >> 30) * v) >> 30);
  endfunction

  // eased value in Q30 for a clamped Q30 progress
  function automatic longint curve_value(input func_t fn, input longint unsigned xq);
    longint unsigned half;
    longint s;
    bit at_end;
    half = ONE30 >> 1;
    at_end = (xq == 0) || (xq == ONE30);
    case (fn)
      FN_LIN:   return longint'(xq);
      FN_IN:    return cubed(xq);
      FN_OUT:   return longint'(ONE30) - cubed(ONE30 - xq);
      FN_INOUT: begin
        if (xq < half) return 4 * cubed(xq);
        return longint'(ONE30) - cubed(2 * (ONE30 - xq)) / 2;
      end
      FN_IN_EL: begin
        if (at_end) return longint'(xq);
        s = sine_turns((10 * xq + 12 * ONE30 - 43 * ONE30 / 4) / 3);
        return -scale_signed(pow2_neg(10 * (ONE30 - xq)), s);
      end
      FN_OUT_EL: begin
        if (at_end) return longint'(xq);
        s = sine_turns((10 * xq + 3 * ONE30 - 3 * ONE30 / 4) / 3);
        return scale_signed(pow2_neg(10 * xq), s) + longint'(ONE30);
      end
      FN_INOUT_EL: begin
        if (at_end) return longint'(xq);
        s = sine_turns((40 * xq + 27 * ONE30 - 89 * ONE30 / 4) / 9);
        if (xq < half) return -scale_signed(pow2_neg(10 * ONE30 - 20 * xq), s) / 2;
        return scale_signed(pow2_neg(20 * xq - 10 * ONE30), s) / 2 + longint'(ONE30);
      end
      FN_STEP:  return (xq < half) ? 0 : longint'(ONE30);
      FN_INST:  return longint'(ONE30);
      default:  return -longint'(ONE30);
    endcase
  endfunction

  // clamp, evaluate, round half-up to 16 fraction bits, saturate
  function automatic eased_t eased_of(input func_t fn, input prog_t prog);
    longint x, v, res;
    longint unsigned u;
    x = prog;
    if (x < 0) x = 0;
    if (x > 65536) x = 65536;
    v = curve_value(fn, longint'(x) << 14);
    u = longint'(v + 4 * longint'(ONE30));
    u = (u + (64'd1 << 13)) >> 14;
    res = longint'(u) - 4 * 65536;
    if (res > 131071) res = 131071;
    if (res < -131072) res = -131072;
    return eased_t'(res);
  endfunction

  // one request: optional idle gap, then hold until taken
  task automatic send_req(input func_t fn, input prog_t prog);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.func     <= fn;
    in_chan.progress <= prog;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    eased_q.push_back(eased_of(fn, prog));
    per_func[fn]++;
    req_cnt++;
  endtask

  task automatic release_chan();
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic prog_t pick_progress();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return prog_t'($urandom());
    if (sel < 25) return prog_t'($urandom_range(65546) - 10 + 0);
    if (sel < 35) return prog_t'(32768 + $urandom_range(20) - 10);
    return prog_t'($urandom_range(65536));
  endfunction

  // range ends, clamping and curve endpoints for every selector
  task automatic test_directed();
    prog_t pts[6];
    pts = '{prog_t'(-131072), prog_t'(0), prog_t'(32767), prog_t'(32768),
            prog_t'(65536), prog_t'(131071)};
    for (int f = 0; f <= 8; f++) begin
      send_req(func_t'(f), pts[f % 6]);
      send_req(func_t'(f), pts[(f + 3) % 6]);
    end
    send_req(func_t'(9), prog_t'(100));
    send_req(func_t'(15), prog_t'(-5));
    send_req(FN_IN_EL, prog_t'(1));
    send_req(FN_OUT_EL, prog_t'(65535));
    send_req(FN_INOUT_EL, prog_t'(32767));
    send_req(FN_INOUT_EL, prog_t'(32768));
    release_chan();
  endtask

  task automatic test_random(input int n);
    func_t fn;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(9) == 0) ? func_t'($urandom_range(15)) : func_t'($urandom_range(8));
      send_req(fn, pick_progress());
    end
    release_chan();
  endtask

  // back-to-back requests with the result side always ready
  task automatic test_burst(input int n);
    no_idle = 1'b1;
    test_random(n);
    no_idle = 1'b0;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_cnt++;
      if (eased_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result eased=%0d", out_chan.eased);
      end else begin
        eased_t exp_val;
        exp_val = eased_q.pop_front();
        if (out_chan.eased !== exp_val) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: eased expected %0d got %0d",
                     result_cnt, exp_val, out_chan.eased);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.func     = FN_LIN;
    in_chan.progress = '0;
    out_chan.ready   = 1'b0;
    foreach (per_func[i]) per_func[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(700);
    test_burst(200);
    test_random(130);

    while (eased_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests over all selectors (%0d with unknown codes), %0d results seen",
             req_cnt, req_cnt - per_func[0] - per_func[1] - per_func[2] - per_func[3]
             - per_func[4] - per_func[5] - per_func[6] - per_func[7] - per_func[8],
             result_cnt);
    if (mismatch_cnt == 0 && eased_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
